/* design/hslrgb_pkg.sv */
package hslrgb_pkg;

   // Fixed-point scales
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
   localparam logic [15:0] HUE_CIRCLE  = 16'd46080;
   localparam logic [12:0] SECTOR_SPAN = 13'd7680;
   localparam logic [15:0] HALF_LEVEL  = 16'd32768;
   localparam logic [16:0] TWICE_FULL  = 17'd131070;

   // Rounding terms and the reciprocal of 15 (exact for 20-bit dividends)
   localparam logic [31:0] ROUND_Q16   = 32'd32767;
   localparam logic [28:0] ROUND_SPAN  = 29'd3840;
   localparam logic [20:0] RECIP_15    = 21'd1118482;

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // Operands of the final channel mix
   typedef struct packed {
      sector_type  sector;
      logic [15:0] chroma;
      logic [15:0] second;
      logic [15:0] offset;
   } mix_type;

   // One RGB pixel
   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } chan_type;

   // Hue at the start of a sector
   function automatic logic [15:0] sector_base(input sector_type sector);
      logic [15:0] base;
      unique case (sector)
         SECTOR_0: base = 16'd0;
         SECTOR_1: base = 16'd7680;
         SECTOR_2: base = 16'd15360;
         SECTOR_3: base = 16'd23040;
         SECTOR_4: base = 16'd30720;
         SECTOR_5: base = 16'd38400;
         default:  base = 16'd0;
      endcase
      return base;
   endfunction

endpackage

/* design/hsv_hsl_to_rgb.sv */
// Hue/saturation/level to RGB converter with alpha pass-through.
//
// Input channel req_*: one pixel per item, tdata = {alpha_in, level,
// saturation, hue}, hue in 1/128 degree, the rest Q0.16 (65535 is 1.0).
// Result channel rsp_*: one pixel per item, tdata = {alpha_out, blue,
// green, red}. Every input item gives exactly one result item, in order.
// csr_wen/csr_wdata write the mode bit (0 HSV, 1 HSL); write it only while
// no item is in flight.
//
// The pipeline takes one item per cycle unless a stalled result holds it;
// its depth is set by the chain of two multipliers (chroma, then secondary
// component) with their rounding divides spread over stages.
// Reset clears all stage valid bits and sets mode to HSV. When the receiver
// holds rsp_tready low the result stays put and stages behind it keep
// filling any empty slot; req_tready falls once every stage holds an item.
module hsv_hsl_to_rgb
   import hslrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // hue, saturation, level, alpha_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // red, green, blue, alpha_out
);

   logic        mode_ff;
   logic [7:1]  valid_ff;
   logic [7:1]  valid_in;
   logic [7:1]  stage_en;

   // Stage 1: wrapped hue, multiplicand
   logic [15:0] s1_hue_ff, s1_hue_in;
   logic [15:0] s1_mult_ff, s1_mult_in;
   logic [15:0] s1_sat_ff, s1_lev_ff, s1_alpha_ff;
   logic [15:0] req_hue, req_sat, req_lev, req_alpha;
   // Stage 2: raw chroma product, sector, ramp
   logic [31:0] s2_prod_ff, s2_prod_in;
   sector_type  s2_sector_ff, s2_sector_in;
   logic [12:0] s2_ramp_ff, s2_ramp_in;
   logic [15:0] s2_lev_ff, s2_alpha_ff;
   logic [15:0] s2_frac;
   // Stage 3: quotient estimate
   logic [31:0] s3_sum_ff, s3_sum_in;
   logic [16:0] s3_quot_ff, s3_quot_in;
   sector_type  s3_sector_ff;
   logic [12:0] s3_ramp_ff;
   logic [15:0] s3_lev_ff, s3_alpha_ff;
   logic [32:0] s3_acc;
   // Stage 4: chroma
   logic [15:0] s4_chroma_ff, s4_chroma_in;
   sector_type  s4_sector_ff;
   logic [12:0] s4_ramp_ff;
   logic [15:0] s4_lev_ff, s4_alpha_ff;
   logic [32:0] s4_rem;
   // Stage 5: scaled secondary numerator, offset
   logic [19:0] s5_num_ff, s5_num_in;
   logic [15:0] s5_offset_ff, s5_offset_in;
   logic [15:0] s5_chroma_ff, s5_alpha_ff;
   sector_type  s5_sector_ff;
   logic [28:0] s5_prod;
   // Stage 6: secondary component
   logic [15:0] s6_second_ff, s6_second_in;
   logic [15:0] s6_offset_ff, s6_chroma_ff, s6_alpha_ff;
   sector_type  s6_sector_ff;
   logic [40:0] s6_prod;
   // Stage 7: output pixel
   chan_type    s7_pixel_ff, s7_pixel_in;
   logic [15:0] s7_alpha_ff;
   mix_type     s6_mix;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wen) begin
         mode_ff <= csr_wdata;
      end
   end

   // A stage loads when it is empty or its item moves on
   assign stage_en[7] = !valid_ff[7] || rsp_tready;
   assign stage_en[6] = !valid_ff[6] || stage_en[7];
   assign stage_en[5] = !valid_ff[5] || stage_en[6];
   assign stage_en[4] = !valid_ff[4] || stage_en[5];
   assign stage_en[3] = !valid_ff[3] || stage_en[4];
   assign stage_en[2] = !valid_ff[2] || stage_en[3];
   assign stage_en[1] = !valid_ff[1] || stage_en[2];
   assign req_tready  = stage_en[1];

   assign valid_in = {valid_ff[6:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 1; i <= 7; i++) begin
            if (stage_en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   // Stage 1: wrap hue, form level or tent-shaped lightness term
   assign req_hue   = req_tdata[15:0];
   assign req_sat   = req_tdata[31:16];
   assign req_lev   = req_tdata[47:32];
   assign req_alpha = req_tdata[63:48];

   assign s1_hue_in = (req_hue >= HUE_CIRCLE) ? req_hue - HUE_CIRCLE : req_hue;

   always_comb begin
      logic [16:0] twice;
      twice = {req_lev, 1'b0};
      if (!mode_ff) begin
         s1_mult_in = req_lev;
      end else if (req_lev >= HALF_LEVEL) begin
         s1_mult_in = 16'(TWICE_FULL - twice);
      end else begin
         s1_mult_in = twice[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_hue_ff   <= s1_hue_in;
         s1_mult_ff  <= s1_mult_in;
         s1_sat_ff   <= req_sat;
         s1_lev_ff   <= req_lev;
         s1_alpha_ff <= req_alpha;
      end
   end

   // Stage 2: chroma product, hue sector and ramp within it
   assign s2_prod_in = s1_mult_ff * s1_sat_ff;

   always_comb begin
      if (s1_hue_ff >= sector_base(SECTOR_5))      s2_sector_in = SECTOR_5;
      else if (s1_hue_ff >= sector_base(SECTOR_4)) s2_sector_in = SECTOR_4;
      else if (s1_hue_ff >= sector_base(SECTOR_3)) s2_sector_in = SECTOR_3;
      else if (s1_hue_ff >= sector_base(SECTOR_2)) s2_sector_in = SECTOR_2;
      else if (s1_hue_ff >= sector_base(SECTOR_1)) s2_sector_in = SECTOR_1;
      else                                         s2_sector_in = SECTOR_0;
   end

   assign s2_frac    = s1_hue_ff - sector_base(s2_sector_in);
   assign s2_ramp_in = s2_sector_in[0] ? SECTOR_SPAN - s2_frac[12:0] : s2_frac[12:0];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_prod_ff   <= s2_prod_in;
         s2_sector_ff <= s2_sector_in;
         s2_ramp_ff   <= s2_ramp_in;
         s2_lev_ff    <= s1_lev_ff;
         s2_alpha_ff  <= s1_alpha_ff;
      end
   end

   // Stage 3: round and estimate the quotient by 65535 (low by at most one)
   assign s3_sum_in  = s2_prod_ff + ROUND_Q16;
   assign s3_acc     = {1'b0, s3_sum_in} + {17'd0, s3_sum_in[31:16]};
   assign s3_quot_in = s3_acc[32:16];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_sum_ff    <= s3_sum_in;
         s3_quot_ff   <= s3_quot_in;
         s3_sector_ff <= s2_sector_ff;
         s3_ramp_ff   <= s2_ramp_ff;
         s3_lev_ff    <= s2_lev_ff;
         s3_alpha_ff  <= s2_alpha_ff;
      end
   end

   // Stage 4: correct the estimate from the remainder
   assign s4_rem = {1'b0, s3_sum_ff} - ({s3_quot_ff, 16'd0} - {16'd0, s3_quot_ff});
   assign s4_chroma_in = s3_quot_ff[15:0] + {15'd0, (s4_rem >= {17'd0, FULL_SCALE})};

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_chroma_ff <= s4_chroma_in;
         s4_sector_ff <= s3_sector_ff;
         s4_ramp_ff   <= s3_ramp_ff;
         s4_lev_ff    <= s3_lev_ff;
         s4_alpha_ff  <= s3_alpha_ff;
      end
   end

   // Stage 5: chroma times ramp, rounded and divided by 512; offset
   assign s5_prod      = s4_chroma_ff * s4_ramp_ff + ROUND_SPAN;
   assign s5_num_in    = s5_prod[28:9];
   assign s5_offset_in = mode_ff ? s4_lev_ff - {1'b0, s4_chroma_ff[15:1]}
                                 : s4_lev_ff - s4_chroma_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_num_ff    <= s5_num_in;
         s5_offset_ff <= s5_offset_in;
         s5_chroma_ff <= s4_chroma_ff;
         s5_sector_ff <= s4_sector_ff;
         s5_alpha_ff  <= s4_alpha_ff;
      end
   end

   // Stage 6: divide by 15 through the reciprocal
   assign s6_prod      = s5_num_ff * RECIP_15;
   assign s6_second_in = s6_prod[39:24];

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_second_ff <= s6_second_in;
         s6_offset_ff <= s5_offset_ff;
         s6_chroma_ff <= s5_chroma_ff;
         s6_sector_ff <= s5_sector_ff;
         s6_alpha_ff  <= s5_alpha_ff;
      end
   end

   // Stage 7: route, add offset, clamp; this is the output register
   assign s6_mix.sector = s6_sector_ff;
   assign s6_mix.chroma = s6_chroma_ff;
   assign s6_mix.second = s6_second_ff;
   assign s6_mix.offset = s6_offset_ff;

   hslrgb_mix u_mix (
      .mix   (s6_mix),
      .pixel (s7_pixel_in)
   );

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_pixel_ff <= s7_pixel_in;
         s7_alpha_ff <= s6_alpha_ff;
      end
   end

   assign rsp_tvalid = valid_ff[7];
   assign rsp_tdata  = {s7_alpha_ff, s7_pixel_ff.blue, s7_pixel_ff.green, s7_pixel_ff.red};

endmodule

/* design/hslrgb_mix.sv */
module hslrgb_mix
   import hslrgb_pkg::*;
(
   input  mix_type  mix,
   output chan_type pixel
);

   logic [15:0] red_comp;
   logic [15:0] green_comp;
   logic [15:0] blue_comp;
   logic [16:0] red_sum;
   logic [16:0] green_sum;
   logic [16:0] blue_sum;

   // Route chroma, secondary and zero by sector
   always_comb begin
      unique case (mix.sector)
         SECTOR_0: begin
            red_comp = mix.chroma; green_comp = mix.second; blue_comp = 16'd0;
         end
         SECTOR_1: begin
            red_comp = mix.second; green_comp = mix.chroma; blue_comp = 16'd0;
         end
         SECTOR_2: begin
            red_comp = 16'd0; green_comp = mix.chroma; blue_comp = mix.second;
         end
         SECTOR_3: begin
            red_comp = 16'd0; green_comp = mix.second; blue_comp = mix.chroma;
         end
         SECTOR_4: begin
            red_comp = mix.second; green_comp = 16'd0; blue_comp = mix.chroma;
         end
         default: begin
            red_comp = mix.chroma; green_comp = 16'd0; blue_comp = mix.second;
         end
      endcase
   end

   // Add the offset and clamp at full scale
   assign red_sum   = {1'b0, red_comp} + {1'b0, mix.offset};
   assign green_sum = {1'b0, green_comp} + {1'b0, mix.offset};
   assign blue_sum  = {1'b0, blue_comp} + {1'b0, mix.offset};

   assign pixel.red   = red_sum[16] ? FULL_SCALE : red_sum[15:0];
   assign pixel.green = green_sum[16] ? FULL_SCALE : green_sum[15:0];
   assign pixel.blue  = blue_sum[16] ? FULL_SCALE : blue_sum[15:0];

endmodule

/* design/hslrgb_checker.sv */
module hslrgb_checker
   import hslrgb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic [3:0] flight_ff;
   logic [3:0] flight_in;
   logic       take_item;
   logic       give_item;

   // Count items inside the block
   assign take_item = req_tvalid && req_tready;
   assign give_item = rsp_tvalid && rsp_tready;
   assign flight_in = flight_ff + {3'd0, take_item} - {3'd0, give_item};

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= 4'd0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // No result without an item inside
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> flight_ff != 4'd0)
      else $error("result shown with no item in flight");

   // Never more items inside than pipeline stages
   assert property (@(posedge clock) disable iff (reset)
      flight_ff <= 4'd7)
      else $error("more items in flight than stages");

   // Reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind hsv_hsl_to_rgb hslrgb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/tb_hsv_hsl_to_rgb.sv */
`timescale 1ns / 100ps

module tb_hsv_hsl_to_rgb;
   import hslrgb_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int PIPE_LATENCY   = 6;
   localparam int RANDOM_BLOCKS  = 6;
   localparam int BLOCK_ITEMS    = 180;
   localparam int NUM_DIRECTED   = 21;
   localparam int LONG_HOLD      = 400;

   // Register values
   localparam bit MODE_HSV = 1'b0;
   localparam bit MODE_HSL = 1'b1;

   // One RGBA pixel, red in the low bits as on rsp_tdata
   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } rgba_type;

   // One directed item; the channels only count where known_rgb is set
   typedef struct packed {
      bit          hsl;
      bit          known_rgb;
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] lev;
      logic [15:0] alpha;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // hue, saturation, level, alpha_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // red, green, blue, alpha_out

   rgba_type    pending_pixels[$];
   bit          mode_q = MODE_HSV;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned backpressure_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // HSV: black, white, primaries and secondaries at full chroma
      '{MODE_HSV, 1'b1, 16'd0,     16'd0,     16'd0,     16'd0,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSV, 1'b1, 16'd0,     16'd0,     16'd65535, 16'd65535,
        16'd65535, 16'd65535, 16'd65535},
      '{MODE_HSV, 1'b1, 16'd0,     16'd65535, 16'd65535, 16'd1,
        16'd65535, 16'd0,     16'd0},
      '{MODE_HSV, 1'b1, 16'd7680,  16'd65535, 16'd65535, 16'd32768,
        16'd65535, 16'd65535, 16'd0},
      '{MODE_HSV, 1'b1, 16'd15360, 16'd65535, 16'd65535, 16'd32767,
        16'd0,     16'd65535, 16'd0},
      '{MODE_HSV, 1'b1, 16'd23040, 16'd65535, 16'd65535, 16'd43690,
        16'd0,     16'd65535, 16'd65535},
      '{MODE_HSV, 1'b1, 16'd30720, 16'd65535, 16'd65535, 16'd21845,
        16'd0,     16'd0,     16'd65535},
      '{MODE_HSV, 1'b1, 16'd38400, 16'd65535, 16'd65535, 16'd65534,
        16'd65535, 16'd0,     16'd65535},
      // top of the circle, then hue wrapping past it
      '{MODE_HSV, 1'b0, 16'd46079, 16'd65535, 16'd65535, 16'd4660,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSV, 1'b1, 16'd46080, 16'd65535, 16'd65535, 16'd0,
        16'd65535, 16'd0,     16'd0},
      '{MODE_HSV, 1'b0, 16'd65535, 16'd40000, 16'd50000, 16'd65535,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSV, 1'b0, 16'd3840,  16'd32768, 16'd40000, 16'd100,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSV, 1'b0, 16'd12345, 16'd65535, 16'd1,     16'd200,
        16'd0,     16'd0,     16'd0},
      // HSL: black, white, mid grey, then around half lightness
      '{MODE_HSL, 1'b1, 16'd0,     16'd65535, 16'd0,     16'd65535,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSL, 1'b1, 16'd20000, 16'd65535, 16'd65535, 16'd0,
        16'd65535, 16'd65535, 16'd65535},
      '{MODE_HSL, 1'b1, 16'd9999,  16'd0,     16'd32768, 16'd12345,
        16'd32768, 16'd32768, 16'd32768},
      '{MODE_HSL, 1'b0, 16'd0,     16'd65535, 16'd32767, 16'd1,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSL, 1'b0, 16'd0,     16'd65535, 16'd32768, 16'd2,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSL, 1'b0, 16'd46079, 16'd65535, 16'd32768, 16'd3,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSL, 1'b0, 16'd65535, 16'd50000, 16'd40000, 16'd65535,
        16'd0,     16'd0,     16'd0},
      '{MODE_HSL, 1'b0, 16'd20000, 16'd65535, 16'd50000, 16'd0,
        16'd0,     16'd0,     16'd0}
   };

   hsv_hsl_to_rgb uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Convert one pixel under the given mode
   function automatic rgba_type convert_pixel(input bit hsl, input logic [15:0] hue,
                                              input logic [15:0] sat, input logic [15:0] lev,
                                              input logic [15:0] alpha);
      logic [15:0] hue_w;
      logic [16:0] twice;
      logic [16:0] tent_dist;
      logic [15:0] lum_span;
      logic [32:0] chroma_prod;
      logic [15:0] chroma;
      logic [15:0] offset;
      logic [12:0] frac;
      logic [12:0] ramp;
      logic [28:0] second_prod;
      logic [15:0] second;
      sector_type  sector;
      logic [16:0] sum_r, sum_g, sum_b;
      logic [15:0] comp_r, comp_g, comp_b;
      rgba_type    px;

      // wrap hue back onto the circle
      hue_w = (hue >= HUE_CIRCLE) ? hue - HUE_CIRCLE : hue;

      // chroma and offset
      if (hsl) begin
         twice = {lev, 1'b0};
         tent_dist = (twice >= {1'b0, FULL_SCALE}) ? twice - {1'b0, FULL_SCALE}
                                                   : {1'b0, FULL_SCALE} - twice;
         lum_span = FULL_SCALE - tent_dist[15:0];
         chroma_prod = lum_span * sat + ROUND_Q16;
      end else begin
         chroma_prod = lev * sat + ROUND_Q16;
      end
      chroma = 16'(chroma_prod / FULL_SCALE);
      offset = hsl ? lev - (chroma >> 1) : lev - chroma;

      // secondary component from the position within the sector
      sector = sector_type'(3'(hue_w / SECTOR_SPAN));
      frac = 13'(hue_w % SECTOR_SPAN);
      ramp = sector[0] ? SECTOR_SPAN - frac : frac;
      second_prod = chroma * ramp + ROUND_SPAN;
      second = 16'(second_prod / SECTOR_SPAN);

      // route components by sector
      case (sector)
         SECTOR_0: begin comp_r = chroma; comp_g = second; comp_b = '0;     end
         SECTOR_1: begin comp_r = second; comp_g = chroma; comp_b = '0;     end
         SECTOR_2: begin comp_r = '0;     comp_g = chroma; comp_b = second; end
         SECTOR_3: begin comp_r = '0;     comp_g = second; comp_b = chroma; end
         SECTOR_4: begin comp_r = second; comp_g = '0;     comp_b = chroma; end
         default:  begin comp_r = chroma; comp_g = '0;     comp_b = second; end
      endcase

      // add offset and clamp
      sum_r = {1'b0, comp_r} + {1'b0, offset};
      sum_g = {1'b0, comp_g} + {1'b0, offset};
      sum_b = {1'b0, comp_b} + {1'b0, offset};
      px.red   = sum_r[16] ? FULL_SCALE : sum_r[15:0];
      px.green = sum_g[16] ? FULL_SCALE : sum_g[15:0];
      px.blue  = sum_b[16] ? FULL_SCALE : sum_b[15:0];
      px.alpha = alpha;
      return px;
   endfunction

   function automatic logic [15:0] pick_fraction();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = 16'd0;
         1: v = FULL_SCALE;
         2: v = 16'd32766 + 16'($urandom_range(3));
         3: v = 16'($urandom_range(15));
         default: v = 16'($urandom_range(65535));
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_hue();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = 16'($urandom_range(65535, 46080));
         1, 2: v = 16'($urandom_range(6) * 7680 + $urandom_range(2) - 1);
         default: v = 16'($urandom_range(46079));
      endcase
      return v;
   endfunction

   // Offer one pixel, with random idle cycles ahead of it
   task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
                             input logic [15:0] lev, input logic [15:0] alpha,
                             input bit known_rgb, input rgba_type known_px);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {alpha, lev, sat, hue};
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(known_rgb ? known_px
                               : convert_pixel(mode_q, hue, sat, lev, alpha));
   endtask

   // Hold the sender until every pixel in flight has come back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit hsl);
      csr_wen   <= 1'b1;
      csr_wdata <= hsl;
      @(posedge clock);
      csr_wen   <= 1'b0;
      mode_q = hsl;
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each returned pixel with the oldest prediction
   always @(posedge clock) begin
      rgba_type want;
      rgba_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rgba_type'(rsp_tdata);
         if (pending_pixels.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("red",       want.red,   got.red);
            check_field("green",     want.green, got.green);
            check_field("blue",      want.blue,  got.blue);
            check_field("alpha_out", want.alpha, got.alpha);
         end
      end
   end

   // Receiver: random stalls, plus one long hold when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (backpressure_left != 0) begin
            rsp_tready <= 1'b0;
            backpressure_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      rgba_type         known_px;
      bit               mode_plan [RANDOM_BLOCKS] = '{MODE_HSL, MODE_HSV, MODE_HSL,
                                                      MODE_HSV, MODE_HSV, MODE_HSL};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(MODE_HSV);

      // Directed items
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.hsl != mode_q) begin
            drain_pipeline();
            write_mode(row.hsl);
         end
         known_px.red   = row.red;
         known_px.green = row.green;
         known_px.blue  = row.blue;
         known_px.alpha = row.alpha;
         send_pixel(row.hue, row.sat, row.lev, row.alpha, row.known_rgb, known_px);
      end

      // Random blocks, each under one mode and one idling profile
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         drain_pipeline();
         write_mode(mode_plan[blk]);
         case (blk / 2)
            0: begin sender_idle_pct = 25; receiver_idle_pct = 73; end
            1: begin sender_idle_pct = 73; receiver_idle_pct = 25; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if (blk == 0 && n == 40) backpressure_left = LONG_HOLD;
            send_pixel(pick_hue(), pick_fraction(), pick_fraction(),
                       16'($urandom_range(65535)), 1'b0, '0);
         end
      end

      drain_pipeline();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
